/* rtl/rbc_pkg.sv */
// package for the reconnect backoff controller
// holds field widths, event and status codes, register map and shared struct types
// no dependencies
`default_nettype none

package rbc_pkg;

    localparam int FUNC_W   = 3;
    localparam int REASON_W = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 16;
    localparam int DELAY_W  = 48;
    localparam int TIME_W   = 64;
    localparam int APB_DW   = 64;
    localparam int APB_AW   = 5;

    localparam logic [DELAY_W-1:0] INIT_DELAY_RST = 48'd500000000;
    localparam logic [DELAY_W-1:0] DELAY_CAP_RST  = 48'd5000000000;
    localparam logic [COUNT_W-1:0] LIMIT_RST      = 16'd0;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 16'hFFFF;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_POLL    = 3'd0,
        FUNC_OPEN    = 3'd1,
        FUNC_REQUEST = 3'd2,
        FUNC_ATTEMPT = 3'd3,
        FUNC_SUCCESS = 3'd4,
        FUNC_FAILURE = 3'd5,
        FUNC_DISABLE = 3'd6,
        FUNC_RESET   = 3'd7
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_IDLE         = 2'd0,
        STATUS_REQUESTED    = 2'd1,
        STATUS_RECONNECTING = 2'd2,
        STATUS_DISABLED     = 2'd3
    } status_t;

    // register index, taken from paddr[4:3]
    typedef enum logic [1:0] {
        REG_INITIAL_DELAY = 2'd0,
        REG_DELAY_CAP     = 2'd1,
        REG_ATTEMPT_LIMIT = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [DELAY_W-1:0] initial_delay;
        logic [DELAY_W-1:0] delay_cap;
        logic [COUNT_W-1:0] attempt_limit;
    } cfg_t;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [TIME_W-1:0]   now;
        logic [REASON_W-1:0] reason_code;
    } event_t;

    typedef struct packed {
        logic                go;
        logic [STATUS_W-1:0] status;
        logic [REASON_W-1:0] cause;
        logic [COUNT_W-1:0]  attempts;
        logic [DELAY_W-1:0]  delay_now;
        logic [TIME_W-1:0]   session_id;
        logic [TIME_W-1:0]   recoveries;
        logic [TIME_W-1:0]   request_time;
        logic [TIME_W-1:0]   attempt_time;
        logic [TIME_W-1:0]   success_time;
    } result_t;

endpackage

`default_nettype wire

/* rtl/rbc_if.sv */
// valid/ready channel interfaces for events in and results out
// depends on rbc_pkg
`default_nettype none

interface rbc_event_if
    import rbc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [TIME_W-1:0]   now;
    logic [REASON_W-1:0] reason_code;

    modport source (output valid, func, now, reason_code, input ready);
    modport sink   (input valid, func, now, reason_code, output ready);
endinterface

interface rbc_result_if
    import rbc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                go;
    logic [STATUS_W-1:0] status;
    logic [REASON_W-1:0] cause;
    logic [COUNT_W-1:0]  attempts;
    logic [DELAY_W-1:0]  delay_now;
    logic [TIME_W-1:0]   session_id;
    logic [TIME_W-1:0]   recoveries;
    logic [TIME_W-1:0]   request_time;
    logic [TIME_W-1:0]   attempt_time;
    logic [TIME_W-1:0]   success_time;

    modport source (output valid, go, status, cause, attempts, delay_now, session_id,
                    recoveries, request_time, attempt_time, success_time, input ready);
    modport sink   (input valid, go, status, cause, attempts, delay_now, session_id,
                    recoveries, request_time, attempt_time, success_time, output ready);
endinterface

`default_nettype wire

/* rtl/rbc_apb_regs.sv */
// apb configuration registers: initial delay, delay cap, attempt limit
// depends on rbc_pkg
`default_nettype none

module rbc_apb_regs
    import rbc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [DELAY_W-1:0] init_delay_reg;
    logic [DELAY_W-1:0] delay_cap_reg;
    logic [COUNT_W-1:0] limit_reg;
    logic               wr_en;
    reg_idx_t           idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[4:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_delay_reg <= INIT_DELAY_RST;
            delay_cap_reg  <= DELAY_CAP_RST;
            limit_reg      <= LIMIT_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_INITIAL_DELAY: init_delay_reg <= pwdata[DELAY_W-1:0];
                REG_DELAY_CAP:     delay_cap_reg  <= pwdata[DELAY_W-1:0];
                REG_ATTEMPT_LIMIT: limit_reg      <= pwdata[COUNT_W-1:0];
                REG_UNUSED:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_INITIAL_DELAY: prdata = {{(APB_DW-DELAY_W){1'b0}}, init_delay_reg};
            REG_DELAY_CAP:     prdata = {{(APB_DW-DELAY_W){1'b0}}, delay_cap_reg};
            REG_ATTEMPT_LIMIT: prdata = {{(APB_DW-COUNT_W){1'b0}}, limit_reg};
            REG_UNUSED:        prdata = '0;
        endcase
    end

    assign cfg.initial_delay = init_delay_reg;
    assign cfg.delay_cap     = delay_cap_reg;
    assign cfg.attempt_limit = limit_reg;

endmodule

`default_nettype wire

/* rtl/rbc_core.sv */
// controller state, per-event update and go decision, one event per enabled cycle
// depends on rbc_pkg
`default_nettype none

module rbc_core
    import rbc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   step_en,
    input  wire event_t evt,
    input  wire cfg_t   cfg,
    output result_t     res
);

    logic                requested_reg, requested_next;
    logic                busy_reg,      busy_next;
    logic                off_reg,       off_next;
    logic [REASON_W-1:0] reason_reg,    reason_next;
    logic [COUNT_W-1:0]  attempts_reg,  attempts_next;
    logic [DELAY_W-1:0]  delay_reg,     delay_next;
    logic [TIME_W-1:0]   req_time_reg,  req_time_next;
    logic [TIME_W-1:0]   att_time_reg,  att_time_next;
    logic [TIME_W-1:0]   suc_time_reg,  suc_time_next;
    logic [TIME_W-1:0]   sessions_reg,  sessions_next;
    logic [TIME_W-1:0]   recov_reg,     recov_next;

    func_t               op;
    logic [DELAY_W-1:0]  eff_max;
    logic [DELAY_W-1:0]  doubled;
    logic                limit_cur;
    logic                limit_new;
    logic [TIME_W-1:0]   base;
    logic [TIME_W-1:0]   elapsed;
    status_t             status;

    assign op        = func_t'(evt.func);
    assign eff_max   = (cfg.delay_cap < cfg.initial_delay) ? cfg.initial_delay : cfg.delay_cap;
    // below half the ceiling the top bit is clear, so the shift cannot overflow
    assign doubled   = (delay_reg > (eff_max >> 1)) ? eff_max : {delay_reg[DELAY_W-2:0], 1'b0};
    assign limit_cur = (cfg.attempt_limit != '0) && (attempts_reg >= cfg.attempt_limit);

    always_comb
    begin
        requested_next = requested_reg;
        busy_next      = busy_reg;
        off_next       = off_reg;
        reason_next    = reason_reg;
        attempts_next  = attempts_reg;
        delay_next     = delay_reg;
        req_time_next  = req_time_reg;
        att_time_next  = att_time_reg;
        suc_time_next  = suc_time_reg;
        sessions_next  = sessions_reg;
        recov_next     = recov_reg;
        unique case (op) inside
            FUNC_POLL: ;
            FUNC_OPEN, FUNC_SUCCESS:
            begin
                if (op == FUNC_SUCCESS)
                begin
                    recov_next = recov_reg + 1'b1;
                end
                sessions_next  = sessions_reg + 1'b1;
                requested_next = 1'b0;
                busy_next      = 1'b0;
                off_next       = 1'b0;
                reason_next    = '0;
                attempts_next  = '0;
                delay_next     = cfg.initial_delay;
                suc_time_next  = evt.now;
            end
            FUNC_REQUEST:
            begin
                if (!off_reg && !requested_reg && !busy_reg)
                begin
                    requested_next = 1'b1;
                    req_time_next  = evt.now;
                    reason_next    = evt.reason_code;
                end
            end
            FUNC_ATTEMPT:
            begin
                if (!off_reg)
                begin
                    busy_next     = 1'b1;
                    att_time_next = evt.now;
                    if (attempts_reg != COUNT_MAX)
                    begin
                        attempts_next = attempts_reg + 1'b1;
                    end
                end
            end
            FUNC_FAILURE:
            begin
                busy_next = 1'b0;
                if (limit_cur)
                begin
                    off_next       = 1'b1;
                    requested_next = 1'b0;
                end
                else
                begin
                    requested_next = 1'b1;
                    delay_next     = doubled;
                end
            end
            FUNC_DISABLE:
            begin
                off_next       = 1'b1;
                requested_next = 1'b0;
                busy_next      = 1'b0;
            end
            FUNC_RESET:
            begin
                requested_next = 1'b0;
                busy_next      = 1'b0;
                off_next       = 1'b0;
                reason_next    = '0;
                attempts_next  = '0;
                delay_next     = cfg.initial_delay;
                req_time_next  = '0;
                att_time_next  = '0;
            end
        endcase
    end

    // go is judged on the updated state at the event's own timestamp
    // an attempt stamped at zero looks like no attempt, so the request stamp is the base
    assign limit_new = (cfg.attempt_limit != '0) && (attempts_next >= cfg.attempt_limit);
    assign base      = (att_time_next == '0) ? req_time_next : att_time_next;
    assign elapsed   = evt.now - base;

    always_comb
    begin
        if (off_next)
        begin
            status = STATUS_DISABLED;
        end
        else if (busy_next)
        begin
            status = STATUS_RECONNECTING;
        end
        else if (requested_next)
        begin
            status = STATUS_REQUESTED;
        end
        else
        begin
            status = STATUS_IDLE;
        end
    end

    assign res.go           = !off_next && requested_next && !busy_next && !limit_new
                              && (evt.now >= base)
                              && (elapsed >= {{(TIME_W-DELAY_W){1'b0}}, delay_next});
    assign res.status       = status;
    assign res.cause        = reason_next;
    assign res.attempts     = attempts_next;
    assign res.delay_now    = delay_next;
    assign res.session_id   = sessions_next;
    assign res.recoveries   = recov_next;
    assign res.request_time = req_time_next;
    assign res.attempt_time = att_time_next;
    assign res.success_time = suc_time_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            requested_reg <= 1'b0;
            busy_reg      <= 1'b0;
            off_reg       <= 1'b0;
            reason_reg    <= '0;
            attempts_reg  <= '0;
            delay_reg     <= INIT_DELAY_RST;
            req_time_reg  <= '0;
            att_time_reg  <= '0;
            suc_time_reg  <= '0;
            sessions_reg  <= '0;
            recov_reg     <= '0;
        end
        else if (step_en)
        begin
            requested_reg <= requested_next;
            busy_reg      <= busy_next;
            off_reg       <= off_next;
            reason_reg    <= reason_next;
            attempts_reg  <= attempts_next;
            delay_reg     <= delay_next;
            req_time_reg  <= req_time_next;
            att_time_reg  <= att_time_next;
            suc_time_reg  <= suc_time_next;
            sessions_reg  <= sessions_next;
            recov_reg     <= recov_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_off_excludes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        off_reg |-> !busy_reg)
        else $error("disabled state with an attempt still active");

    a_attempt_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && (op == FUNC_ATTEMPT) && !off_reg) |=> busy_reg)
        else $error("accepted attempt did not mark the controller busy");

    a_off_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(off_reg) |-> ($past(step_en)
            && (($past(op) == FUNC_DISABLE) || ($past(op) == FUNC_FAILURE))))
        else $error("disabled state entered without disable or failure event");

    a_go_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && res.go) |=> (requested_reg && !busy_reg && !off_reg))
        else $error("go raised while not waiting on a request");
`endif

endmodule

`default_nettype wire

/* rtl/reconnect_backoff_controller.sv */
// top level of the reconnect backoff controller: event input stage, core, result stage
// depends on rbc_pkg, rbc_if, rbc_apb_regs, rbc_core
//
//   port        dir    protocol     payload
//   evt         in     valid/ready  func, now, reason_code
//   res         out    valid/ready  go, status, cause, attempts, delay_now, counters, stamps
//   apb (p*)    in     apb write    initial_delay @0x00, delay cap @0x08, attempt_limit @0x10
//
// one event per cycle sustained unless res.ready stalls the result register; an accepted event
// passes the event register, then the state update and go compare into the result register
// the state update and the 64-bit elapsed-time compare are done in the same cycle
// a stalled result holds the event register; no clearing pass after reset
`default_nettype none

module reconnect_backoff_controller
    import rbc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    rbc_event_if.sink              evt,
    rbc_result_if.source           res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    cfg_t    cfg;
    event_t  in_data_reg;
    logic    in_valid_reg;
    result_t out_data_reg;
    logic    out_valid_reg;
    result_t step_res;
    logic    advance;
    logic    step_en;

    rbc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rbc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .evt     (in_data_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    assign advance   = !out_valid_reg || res.ready;
    assign step_en   = in_valid_reg && advance;
    assign evt.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (evt.ready)
            begin
                in_valid_reg <= evt.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            in_data_reg.func        <= evt.func;
            in_data_reg.now         <= evt.now;
            in_data_reg.reason_code <= evt.reason_code;
        end
        if (step_en)
        begin
            out_data_reg <= step_res;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.go           = out_data_reg.go;
    assign res.status       = out_data_reg.status;
    assign res.cause        = out_data_reg.cause;
    assign res.attempts     = out_data_reg.attempts;
    assign res.delay_now    = out_data_reg.delay_now;
    assign res.session_id   = out_data_reg.session_id;
    assign res.recoveries   = out_data_reg.recoveries;
    assign res.request_time = out_data_reg.request_time;
    assign res.attempt_time = out_data_reg.attempt_time;
    assign res.success_time = out_data_reg.success_time;

endmodule

`default_nettype wire

/* tb/sv/reconnect_backoff_checker.sv */
// checker for the reconnect backoff controller: follows register writes and events,
// predicts each result and compares it field by field with what comes out
// depends on rbc_pkg and the rbc_event_if / rbc_result_if interfaces
module reconnect_backoff_checker
    import rbc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    rbc_event_if                   evt,
    rbc_result_if                  res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic              pready,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output int unsigned            fail_count,
    output int unsigned            outstanding
);

    // register copies
    logic [DELAY_W-1:0] cfg_initial;
    logic [DELAY_W-1:0] cfg_max;
    logic [COUNT_W-1:0] cfg_limit;

    // controller state
    logic                pending_req;
    logic                in_attempt;
    logic                shut_off;
    logic [REASON_W-1:0] reason_held;
    logic [COUNT_W-1:0]  attempt_cnt;
    logic [DELAY_W-1:0]  cur_delay;
    logic [TIME_W-1:0]   req_stamp;
    logic [TIME_W-1:0]   att_stamp;
    logic [TIME_W-1:0]   open_stamp;
    logic [TIME_W-1:0]   sessions;
    logic [TIME_W-1:0]   recovered;

    result_t expected_q[$];

    function automatic logic [DELAY_W-1:0] delay_ceiling();
        return (cfg_max < cfg_initial) ? cfg_initial : cfg_max;
    endfunction

    function automatic logic limit_reached();
        return cfg_limit != '0 && attempt_cnt >= cfg_limit;
    endfunction

    task automatic clear_backoff();
        pending_req = 1'b0;
        in_attempt  = 1'b0;
        shut_off    = 1'b0;
        reason_held = '0;
        attempt_cnt = '0;
        cur_delay   = cfg_initial;
    endtask

    function automatic logic go_due(input logic [TIME_W-1:0] stamp);
        logic [TIME_W-1:0] base;
        // an attempt at time zero looks like no attempt, so the request is the base
        base = (att_stamp == '0) ? req_stamp : att_stamp;
        if (shut_off || !pending_req || in_attempt || limit_reached())
            return 1'b0;
        if (stamp < base)
            return 1'b0;
        return (stamp - base) >= {{(TIME_W-DELAY_W){1'b0}}, cur_delay};
    endfunction

    task automatic apply_event(input func_t f, input logic [TIME_W-1:0] stamp,
                               input logic [REASON_W-1:0] reason);
        logic [DELAY_W-1:0] top_delay;
        logic [DELAY_W:0]   doubled;
        case (f)
            FUNC_OPEN:
            begin
                sessions = sessions + 1;
                clear_backoff();
                open_stamp = stamp;
            end
            FUNC_REQUEST:
            begin
                if (!shut_off && !pending_req && !in_attempt)
                begin
                    pending_req = 1'b1;
                    req_stamp   = stamp;
                    reason_held = reason;
                end
            end
            FUNC_ATTEMPT:
            begin
                if (!shut_off)
                begin
                    in_attempt = 1'b1;
                    att_stamp  = stamp;
                    if (attempt_cnt != COUNT_MAX)
                        attempt_cnt = attempt_cnt + 1;
                end
            end
            FUNC_SUCCESS:
            begin
                recovered = recovered + 1;
                sessions  = sessions + 1;
                clear_backoff();
                open_stamp = stamp;
            end
            FUNC_FAILURE:
            begin
                in_attempt = 1'b0;
                if (limit_reached())
                begin
                    shut_off    = 1'b1;
                    pending_req = 1'b0;
                end
                else
                begin
                    pending_req = 1'b1;
                    top_delay   = delay_ceiling();
                    if (cur_delay > (top_delay >> 1))
                        cur_delay = top_delay;
                    else
                    begin
                        doubled   = {cur_delay, 1'b0};
                        cur_delay = (doubled < {1'b0, top_delay}) ? doubled[DELAY_W-1:0]
                                                                  : top_delay;
                    end
                end
            end
            FUNC_DISABLE:
            begin
                shut_off    = 1'b1;
                pending_req = 1'b0;
                in_attempt  = 1'b0;
            end
            FUNC_RESET:
            begin
                clear_backoff();
                req_stamp = '0;
                att_stamp = '0;
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic result_t predicted_result(input logic [TIME_W-1:0] stamp);
        result_t r;
        r.go           = go_due(stamp);
        r.status       = shut_off ? STATUS_DISABLED :
                         in_attempt ? STATUS_RECONNECTING :
                         pending_req ? STATUS_REQUESTED : STATUS_IDLE;
        r.cause        = reason_held;
        r.attempts     = attempt_cnt;
        r.delay_now    = cur_delay;
        r.session_id   = sessions;
        r.recoveries   = recovered;
        r.request_time = req_stamp;
        r.attempt_time = att_stamp;
        r.success_time = open_stamp;
        return r;
    endfunction

    task automatic note_field(input string name, input logic [TIME_W-1:0] want,
                              input logic [TIME_W-1:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    task automatic check_result();
        result_t want;
        if (expected_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: result item with nothing expected", $time);
        end
        else
        begin
            want = expected_q.pop_front();
            note_field("go", want.go, res.go);
            note_field("status", want.status, res.status);
            note_field("cause", want.cause, res.cause);
            note_field("attempts", want.attempts, res.attempts);
            note_field("delay_now", want.delay_now, res.delay_now);
            note_field("session_id", want.session_id, res.session_id);
            note_field("recoveries", want.recoveries, res.recoveries);
            note_field("request_time", want.request_time, res.request_time);
            note_field("attempt_time", want.attempt_time, res.attempt_time);
            note_field("success_time", want.success_time, res.success_time);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_initial = INIT_DELAY_RST;
            cfg_max     = DELAY_CAP_RST;
            cfg_limit   = LIMIT_RST;
            clear_backoff();
            req_stamp   = '0;
            att_stamp   = '0;
            open_stamp  = '0;
            sessions    = '0;
            recovered   = '0;
            fail_count  = 0;
            expected_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
                check_result();
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[4:3]))
                    REG_INITIAL_DELAY: cfg_initial = pwdata[DELAY_W-1:0];
                    REG_DELAY_CAP:     cfg_max     = pwdata[DELAY_W-1:0];
                    REG_ATTEMPT_LIMIT: cfg_limit   = pwdata[COUNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (evt.valid && evt.ready)
            begin
                apply_event(func_t'(evt.func), evt.now, evt.reason_code);
                expected_q.push_back(predicted_result(evt.now));
            end
            outstanding <= expected_q.size();
        end
    end

endmodule

/* tb/sv/reconnect_backoff_controller_test.sv */
// top of the reconnect backoff controller testbench: clock, reset, register writes,
// event stimulus with random idling and the final verdict
// depends on rbc_pkg, the rbc interfaces, the controller and reconnect_backoff_checker
module reconnect_backoff_controller_test;
    import rbc_pkg::*;

    localparam int unsigned PHASE_ITEMS = 80;
    localparam int unsigned BURST_ATTEMPTS = 20;
    localparam longint unsigned RUN_LIMIT = 64'd10_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned send_idle_pct = 34;
    int unsigned recv_idle_pct = 50;
    int unsigned sent = 0;

    logic [TIME_W-1:0] clock_ns = '0;
    logic [TIME_W-1:0] gap_scale = 64'd1000;

    rbc_event_if  evt();
    rbc_result_if res();

    reconnect_backoff_controller DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt     (evt),
        .res     (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    reconnect_backoff_checker result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt         (evt),
        .res         (res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
        res.ready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic logic [TIME_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [REASON_W-1:0] rand_reason();
        return REASON_W'($urandom_range(15));
    endfunction

    // mostly a rising clock, now and then a stray timestamp
    function automatic logic [TIME_W-1:0] next_stamp();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 3)
            return '0;
        if (pick < 5)
            return '1;
        if (pick < 10)
            return rand64();
        if (pick < 40)
            clock_ns = clock_ns + TIME_W'($urandom_range(3));
        else
            clock_ns = clock_ns + rand64() % (gap_scale * 2 + 1);
        return clock_ns;
    endfunction

    task automatic push_event(input func_t f, input logic [TIME_W-1:0] stamp,
                              input logic [REASON_W-1:0] reason);
        while ($urandom_range(99) < send_idle_pct)
        begin
            evt.valid <= 1'b0;
            @(posedge clk);
        end
        evt.valid       <= 1'b1;
        evt.func        <= f;
        evt.now         <= stamp;
        evt.reason_code <= reason;
        do
            @(posedge clk);
        while (!evt.ready);
        sent++;
    endtask

    task automatic drain();
        evt.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [DELAY_W-1:0] first_delay,
                              input logic [DELAY_W-1:0] ceiling,
                              input logic [COUNT_W-1:0] limit,
                              input logic [TIME_W-1:0] scale);
        drain();
        write_reg(REG_INITIAL_DELAY, {16'd0, first_delay});
        write_reg(REG_DELAY_CAP, {16'd0, ceiling});
        write_reg(REG_ATTEMPT_LIMIT, {48'd0, limit});
        gap_scale = scale;
    endtask

    // request, then a few attempt/failure rounds with polls between them; a success ends it early
    task automatic run_episode();
        int unsigned rounds;
        if ($urandom_range(3) == 0)
            push_event(FUNC_OPEN, next_stamp(), rand_reason());
        push_event(FUNC_REQUEST, next_stamp(), rand_reason());
        rounds = $urandom_range(1, 6);
        repeat (rounds)
        begin
            repeat ($urandom_range(2))
                push_event(FUNC_POLL, next_stamp(), rand_reason());
            push_event(FUNC_ATTEMPT, next_stamp(), rand_reason());
            if ($urandom_range(1) == 1)
                push_event(FUNC_POLL, next_stamp(), rand_reason());
            if ($urandom_range(4) == 0)
            begin
                push_event(FUNC_SUCCESS, next_stamp(), rand_reason());
                return;
            end
            push_event(FUNC_FAILURE, next_stamp(), rand_reason());
            if ($urandom_range(9) == 0)
                push_event(FUNC_REQUEST, next_stamp(), rand_reason());
        end
        case ($urandom_range(5))
            0: push_event(FUNC_DISABLE, next_stamp(), rand_reason());
            1: push_event(FUNC_RESET, next_stamp(), rand_reason());
            default:
            begin
            end
        endcase
    endtask

    task automatic run_phase(input int unsigned count);
        int unsigned start;
        start = sent;
        while (sent - start < count)
        begin
            if ($urandom_range(6) == 0)
                push_event(func_t'($urandom_range(7)), next_stamp(), rand_reason());
            else
                run_episode();
        end
    endtask

    initial
    begin
        #(RUN_LIMIT);
        $display("reconnect_backoff_controller regression: fail");
        $finish;
    end

    initial
    begin
        evt.valid       <= 1'b0;
        evt.func        <= FUNC_POLL;
        evt.now         <= '0;
        evt.reason_code <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset settings: 500 ms first delay, 5 s ceiling, no limit
        push_event(FUNC_POLL, 64'd0, 4'd15);
        push_event(FUNC_REQUEST, 64'd0, 4'd15);
        push_event(FUNC_REQUEST, 64'd10, 4'd3);
        push_event(FUNC_POLL, 64'd499999999, 4'd0);
        push_event(FUNC_POLL, 64'd500000000, 4'd0);
        // attempt at time zero keeps the request as the base
        push_event(FUNC_ATTEMPT, 64'd0, 4'd0);
        push_event(FUNC_REQUEST, 64'd7, 4'd1);
        push_event(FUNC_FAILURE, 64'd0, 4'd0);
        push_event(FUNC_POLL, 64'd1000000000, 4'd0);
        push_event(FUNC_ATTEMPT, '1, 4'd0);
        push_event(FUNC_FAILURE, '1, 4'd0);
        push_event(FUNC_POLL, 64'd100, 4'd0);
        push_event(FUNC_FAILURE, 64'd5, 4'd0);
        push_event(FUNC_FAILURE, 64'd6, 4'd0);
        push_event(FUNC_SUCCESS, '1, 4'd0);
        push_event(FUNC_REQUEST, 64'h8000_0000_0000_0000, 4'd10);
        push_event(FUNC_DISABLE, 64'd1, 4'd0);
        push_event(FUNC_REQUEST, 64'd2, 4'd5);
        push_event(FUNC_ATTEMPT, 64'd3, 4'd0);
        push_event(FUNC_FAILURE, 64'd4, 4'd0);
        push_event(FUNC_RESET, 64'd5, 4'd0);
        push_event(FUNC_OPEN, 64'd6, 4'd0);
        push_event(FUNC_ATTEMPT, 64'd7, 4'd0);
        push_event(FUNC_POLL, 64'd7, 4'd0);

        set_config(48'd100, 48'd1600, 16'd3, 64'd1600);
        run_phase(PHASE_ITEMS);
        set_config(48'd0, 48'd0, 16'd1, 64'd4);
        run_phase(PHASE_ITEMS);

        send_idle_pct = 50;
        recv_idle_pct = 34;
        set_config(48'hFFFF_FFFF_FFFF, 48'd0, 16'hFFFF, 64'h1_0000_0000_0000);
        run_phase(PHASE_ITEMS);
        // ceiling below the first delay
        set_config(48'd5000, 48'd2000, 16'd0, 64'd5000);
        run_phase(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(48'd1, 48'hFFFF_FFFF_FFFF, 16'd0, 64'd64);
        run_phase(PHASE_ITEMS);
        set_config(48'd37, 48'd1000, 16'd8, 64'd1000);
        run_phase(PHASE_ITEMS);

        // attempt counter runs past the limit, then a failure shuts the controller off
        set_config(48'd1000, 48'd64000, 16'd16, 64'd1000);
        push_event(FUNC_RESET, next_stamp(), 4'd0);
        push_event(FUNC_REQUEST, next_stamp(), 4'd9);
        repeat (BURST_ATTEMPTS)
            push_event(FUNC_ATTEMPT, next_stamp(), rand_reason());
        push_event(FUNC_FAILURE, next_stamp(), 4'd0);
        repeat (4)
            push_event(FUNC_POLL, next_stamp(), 4'd0);
        run_phase(PHASE_ITEMS / 4);

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("reconnect_backoff_controller regression: pass");
        else
            $display("reconnect_backoff_controller regression: fail");
        $finish;
    end

endmodule
